// File: hdl/fpeas_pkg.sv
`timescale 1ns / 1ps
package fpeas_pkg;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2
   } op_type;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

   // Classification of one operand
   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
   } cls_type;

   function automatic cls_type classify(input logic [31:0] x);
      cls_type c;
      c.nan  = x[30:0] > INF_MAG;
      c.inf  = x[30:0] == INF_MAG;
      c.zero = x[30:0] == 31'd0;
      return c;
   endfunction

   // Count leading zeros of a 64-bit word (priority encoder)
   function automatic logic [6:0] clz64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 7'(63 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// File: hdl/fp32_elementwise_add_sub_mul.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_      in         tdata = {second_operand, first_operand}, tlast = last_in
// rsp_      out        tdata = result_bits, tlast = last_out
// csr_      in         wdata = operation (0 mul, 1 add, 2 sub); code 3 ignored
//
// Four register stages: unpack/special detect, multiply or align, normalize,
// round. One item per cycle while the output is not stalled; an item moves
// through the stage registers in that order and leaves from the round stage.
// A stall freezes every full stage whose successor cannot move.
// Synchronous reset clears valid bits and sets operation to multiply.
module fp32_elementwise_add_sub_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] first_operand, [63:32] second_operand
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_bits
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_wdata
);
   import fpeas_pkg::*;

   op_type op_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   // Advance a stage when its successor is free or also moving
   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;
   assign csr_ready  = 1'b1;

   // Hold operation; drop writes of the undefined code
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_MUL;
      end else if (csr_valid) begin
         case (csr_wdata)
            OP_MUL, OP_ADD, OP_SUB: op_ff <= op_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: unpack, special cases, swap ----------------
   logic [31:0] a_w, b_w, big_w, sml_w;
   cls_type     ca, cb;
   logic        spec_w;
   logic [31:0] spec_res_w;
   logic        mul_w, sgn_w;
   logic [23:0] ma_w, mb_w;
   logic [9:0]  ea_w, eb_w;

   always_comb begin
      a_w = req_tdata[31:0];
      b_w = req_tdata[63:32];
      if (op_ff == OP_SUB) b_w[31] = ~b_w[31];
      mul_w = op_ff == OP_MUL;
      ca = classify(a_w);
      cb = classify(b_w);
      spec_w = 1'b1;
      spec_res_w = QNAN_BITS;
      big_w = a_w;
      sml_w = b_w;
      if (mul_w) begin
         sgn_w = a_w[31] ^ b_w[31];
         if (ca.nan || cb.nan) spec_res_w = QNAN_BITS;
         else if (ca.inf || cb.inf)
            spec_res_w = (ca.zero || cb.zero) ? QNAN_BITS : {sgn_w, INF_MAG};
         else if (ca.zero || cb.zero) spec_res_w = {sgn_w, 31'd0};
         else spec_w = 1'b0;
      end else begin
         if (b_w[30:0] > a_w[30:0]) begin
            big_w = b_w;
            sml_w = a_w;
         end
         sgn_w = big_w[31];
         if (ca.nan || cb.nan) spec_res_w = QNAN_BITS;
         else if (ca.inf && cb.inf)
            spec_res_w = (a_w[31] == b_w[31]) ? a_w : QNAN_BITS;
         else if (ca.inf) spec_res_w = a_w;
         else if (cb.inf) spec_res_w = b_w;
         else if (ca.zero && cb.zero) spec_res_w = {a_w[31] & b_w[31], 31'd0};
         else if (ca.zero) spec_res_w = b_w;
         else if (cb.zero) spec_res_w = a_w;
         else spec_w = 1'b0;
      end
      ma_w = {big_w[30:23] != 8'd0, big_w[22:0]};
      mb_w = {sml_w[30:23] != 8'd0, sml_w[22:0]};
      ea_w = (big_w[30:23] == 8'd0) ? 10'd1 : {2'b00, big_w[30:23]};
      eb_w = (sml_w[30:23] == 8'd0) ? 10'd1 : {2'b00, sml_w[30:23]};
   end

   logic        mul1_ff, sgn1_ff, spec1_ff, last1_ff, sub1_ff;
   logic [31:0] sres1_ff;
   logic [23:0] ma1_ff, mb1_ff;
   logic [9:0]  ea1_ff, eb1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv1) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv1) begin
         mul1_ff  <= mul_w;
         sgn1_ff  <= sgn_w;
         sub1_ff  <= big_w[31] ^ sml_w[31];
         spec1_ff <= spec_w;
         sres1_ff <= spec_res_w;
         last1_ff <= req_tlast;
         ma1_ff   <= ma_w;
         mb1_ff   <= mb_w;
         ea1_ff   <= ea_w;
         eb1_ff   <= eb_w;
      end
   end

   // ---------------- stage 2: multiply or align and add ----------------
   // sig2 is a 64-bit value, leading one expected near bit 62,
   // exponent e2 such that value = sig/2^62 * 2^(e2-127)
   logic [47:0] prod_w;
   logic [63:0] xa_w, xb_w, sum_w, sig2_w;
   logic [9:0]  diff_w;
   logic signed [11:0] e2_w;
   logic        zero2_w;

   always_comb begin
      prod_w = 48'(ma1_ff) * 48'(mb1_ff);
      xa_w = {1'b0, ma1_ff, 39'd0};
      xb_w = {1'b0, mb1_ff, 39'd0};
      diff_w = ea1_ff - eb1_ff;
      if (diff_w >= 10'd63) xb_w = 64'd1;
      else if (diff_w != 10'd0)
         xb_w = (xb_w >> diff_w) | 64'((xb_w & ((64'd1 << diff_w) - 64'd1)) != 64'd0);
      sum_w = sub1_ff ? (xa_w - xb_w) : (xa_w + xb_w);
      zero2_w = 1'b0;
      if (mul1_ff) begin
         // product of 24-bit significands: leading one at bit 47 or below (46 or 47 if both normal)
         sig2_w = {1'b0, prod_w, 15'd0};
         e2_w = 12'(signed'({2'b00, ea1_ff})) + 12'(signed'({2'b00, eb1_ff}))
              - 12'sd126;
      end else begin
         zero2_w = sub1_ff && sum_w == 64'd0;
         e2_w = 12'(signed'({2'b00, ea1_ff}));
         if (sum_w[63]) begin
            sig2_w = {1'b0, sum_w[63:2], sum_w[1] | sum_w[0]};
            e2_w = e2_w + 12'sd1;
         end else begin
            sig2_w = sum_w;
         end
      end
   end

   logic        sgn2_ff, spec2_ff, last2_ff, zero2_ff;
   logic [31:0] sres2_ff;
   logic [63:0] sig2_ff;
   logic signed [11:0] e2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv2) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv2) begin
         sgn2_ff  <= sgn1_ff;
         spec2_ff <= spec1_ff;
         sres2_ff <= sres1_ff;
         last2_ff <= last1_ff;
         zero2_ff <= zero2_w;
         sig2_ff  <= sig2_w;
         e2_ff    <= e2_w;
      end
   end

   // ---------------- stage 3: normalize to bit 62, denormal shift ----------------
   logic [6:0]  lz_w;
   logic [63:0] nsig_w, dsig_w;
   logic signed [11:0] e3_w;
   logic [11:0] sh_w;

   always_comb begin
      lz_w = clz64(sig2_ff);
      // leading one at bit 63-lz; move it to bit 62
      nsig_w = sig2_ff << (lz_w - 7'd1);
      e3_w = e2_ff - 12'(signed'({5'd0, lz_w})) + 12'sd1;
      dsig_w = nsig_w;
      sh_w = 12'd0;
      if (e3_w <= 12'sd0) begin
         sh_w = 12'(12'sd1 - e3_w);
         if (sh_w >= 12'd63) dsig_w = 64'(nsig_w != 64'd0);
         else
            dsig_w = (nsig_w >> sh_w[5:0])
                   | 64'((nsig_w & ((64'd1 << sh_w[5:0]) - 64'd1)) != 64'd0);
      end
   end

   logic        sgn3_ff, spec3_ff, last3_ff, zero3_ff, ovf3_ff;
   logic [31:0] sres3_ff;
   logic [63:0] sig3_ff;
   logic [7:0]  ebase3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv3) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv3) begin
         sgn3_ff   <= sgn2_ff;
         spec3_ff  <= spec2_ff;
         sres3_ff  <= sres2_ff;
         last3_ff  <= last2_ff;
         zero3_ff  <= zero2_ff;
         ovf3_ff   <= e3_w >= 12'sd255;
         sig3_ff   <= dsig_w;
         ebase3_ff <= (e3_w <= 12'sd0) ? 8'd0 : 8'(e3_w - 12'sd1);
      end
   end

   // ---------------- stage 4: round and pack ----------------
   logic [23:0] m_w;
   logic [38:0] rem_w;
   logic        up_w;
   logic [31:0] res_w;

   always_comb begin
      m_w = sig3_ff[62:39];
      rem_w = sig3_ff[38:0];
      up_w = (rem_w > {1'b1, 38'd0}) || (rem_w == {1'b1, 38'd0} && m_w[0]);
      res_w = {sgn3_ff, 31'd0} + {1'b0, ebase3_ff, 23'd0} + {8'd0, m_w} + 32'(up_w);
      if (spec3_ff) res_w = sres3_ff;
      else if (zero3_ff) res_w = 32'd0;
      else if (ovf3_ff) res_w = {sgn3_ff, INF_MAG};
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv4) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv4) begin
         rsp_tdata <= res_w;
         rsp_tlast <= last3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;

endmodule

// File: hdl/fpeas_checker.sv
`timescale 1ns / 1ps
module fpeas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);
   // Output stays valid and stable while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed under stall");

   // No result right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is taken whenever output is being drained
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while output drains");

   // A newly valid result needs an item that entered earlier
   a_lat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 4))
      else $error("result without an earlier item");
endmodule

bind fp32_elementwise_add_sub_mul fpeas_checker u_fpeas_checker (.*);
